@@ rtl/smc_pkg.sv @@
// Shared types, codes and constants for the stepper move controller.
`default_nettype none

package smc_pkg;

    localparam logic [2:0] MODE_TICK   = 3'd0;
    localparam logic [2:0] MODE_MOVE   = 3'd1;
    localparam logic [2:0] MODE_ROTATE = 3'd2;
    localparam logic [2:0] MODE_STOP   = 3'd3;
    localparam logic [2:0] MODE_ZERO   = 3'd4;

    localparam logic [1:0] STATUS_NONE      = 2'd0;
    localparam logic [1:0] STATUS_EXECUTING = 2'd1;
    localparam logic [1:0] STATUS_FINISHED  = 2'd2;
    localparam logic [1:0] STATUS_ABORTED   = 2'd3;

    localparam logic [2:0] TRIG_NONE        = 3'd0;
    localparam logic [2:0] TRIG_EXT_STOP    = 3'd1;
    localparam logic [2:0] TRIG_CANNOT_MOVE = 3'd2;
    localparam logic [2:0] TRIG_FWD_SWITCH  = 3'd3;
    localparam logic [2:0] TRIG_BACK_SWITCH = 3'd4;
    localparam logic [2:0] TRIG_FORCE       = 3'd5;

    localparam logic [1:0] CFG_MIN_RATE  = 2'd0;
    localparam logic [1:0] CFG_MAX_RATE  = 2'd1;
    localparam logic [1:0] CFG_MAX_FORCE = 2'd2;

    localparam logic [11:0] MIN_RATE_RESET  = 12'd100;
    localparam logic [11:0] MAX_RATE_RESET  = 12'd1200;
    localparam logic [15:0] MAX_FORCE_RESET = 16'd500;

    localparam int ROTATE_SPAN = 100;

    typedef struct packed {
        logic [2:0]  mode;
        logic        relative;
        logic [31:0] target_offset;
        logic [15:0] rate_request;
        logic [15:0] force_limit;
        logic        rotate_forward;
        logic        limit_forward;
        logic        limit_back;
        logic [15:0] force_sample;
    } item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  trigger;
        logic [31:0] position;
        logic        step_level;
        logic        dir_forward;
        logic        power_on;
        logic [11:0] step_rate;
    } result_t;

    function automatic logic [11:0] clamp_rate(
        input logic [15:0] req,
        input logic [11:0] lo,
        input logic [11:0] hi
    );
        logic [15:0] r;
        r = req;
        if (r < {4'd0, lo})
        begin
            r = {4'd0, lo};
        end
        if (r > {4'd0, hi})
        begin
            r = {4'd0, hi};
        end
        return r[11:0];
    endfunction

endpackage

`default_nettype wire

@@ rtl/smc_in_stage.sv @@
// Input register stage holding one command or tick until the executor takes it.
`default_nettype none

module smc_in_stage (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_stall,
    input  wire smc_pkg::item_t in_item,
    input  wire logic           take,
    output logic                item_valid,
    output smc_pkg::item_t      item
);
    import smc_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  load;

    assign in_stall   = valid_reg && !take;
    assign load       = in_valid && !in_stall;
    assign valid_next = load || (valid_reg && !take);
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= in_item;
        end
    end

endmodule

`default_nettype wire

@@ rtl/smc_exec.sv @@
// Controller state, configuration registers and the per-item state update.
`default_nettype none

module smc_exec #(
    parameter int POSITION_BITS = 32
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           fire,
    input  wire smc_pkg::item_t item,
    input  wire logic           cfg_we,
    input  wire logic [1:0]     cfg_index,
    input  wire logic [15:0]    cfg_wdata,
    output smc_pkg::result_t    result
);
    import smc_pkg::*;

    logic [11:0] min_rate_reg;
    logic [11:0] max_rate_reg;
    logic [15:0] max_force_reg;

    logic [1:0]               status_reg, status_next;
    logic [2:0]               trigger_reg, trigger_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [POSITION_BITS-1:0] target_reg, target_next;
    logic [15:0]              force_lim_reg, force_lim_next;
    logic                     inc_en_reg, inc_en_next;
    logic                     inc_up_reg, inc_up_next;
    logic                     dir_fwd_reg, dir_fwd_next;
    logic                     step_reg, step_next;
    logic                     run_reg, run_next;
    logic [11:0]              rate_reg, rate_next;

    logic [POSITION_BITS-1:0] off_ext;
    logic [POSITION_BITS-1:0] move_target;
    logic                     move_fwd;
    logic                     move_blocked;
    logic [15:0]              move_force;
    logic [11:0]              req_rate;

    assign off_ext      = POSITION_BITS'($signed(item.target_offset));
    assign move_target  = item.relative ? (off_ext + pos_reg) : off_ext;
    assign move_fwd     = $signed(move_target) >= $signed(pos_reg);
    assign move_blocked = move_fwd ? item.limit_forward : item.limit_back;
    assign move_force   = ($signed(item.force_limit) < $signed(max_force_reg)) ?
                          item.force_limit : max_force_reg;
    assign req_rate     = clamp_rate(item.rate_request, min_rate_reg, max_rate_reg);

    always_comb
    begin
        status_next    = status_reg;
        trigger_next   = trigger_reg;
        pos_next       = pos_reg;
        target_next    = target_reg;
        force_lim_next = force_lim_reg;
        inc_en_next    = inc_en_reg;
        inc_up_next    = inc_up_reg;
        dir_fwd_next   = dir_fwd_reg;
        step_next      = step_reg;
        run_next       = run_reg;
        rate_next      = rate_reg;

        unique case (item.mode)
            MODE_TICK:
            begin
                if (run_reg)
                begin
                    if (step_reg)
                    begin
                        step_next = 1'b0;
                    end
                    else
                    begin
                        priority if (dir_fwd_reg && item.limit_forward)
                        begin
                            status_next  = STATUS_ABORTED;
                            trigger_next = TRIG_FWD_SWITCH;
                            run_next     = 1'b0;
                            rate_next    = '0;
                        end
                        else if (!dir_fwd_reg && item.limit_back)
                        begin
                            status_next  = STATUS_ABORTED;
                            trigger_next = TRIG_BACK_SWITCH;
                            pos_next     = '0;
                            run_next     = 1'b0;
                            rate_next    = '0;
                        end
                        else if (dir_fwd_reg &&
                                 ($signed(item.force_sample) >= $signed(force_lim_reg)))
                        begin
                            status_next  = STATUS_ABORTED;
                            trigger_next = TRIG_FORCE;
                            run_next     = 1'b0;
                            rate_next    = '0;
                        end
                        else if (pos_reg == target_reg)
                        begin
                            status_next  = STATUS_FINISHED;
                            trigger_next = TRIG_NONE;
                            run_next     = 1'b0;
                            rate_next    = '0;
                        end
                        else
                        begin
                            if (inc_en_reg)
                            begin
                                pos_next = inc_up_reg ? (pos_reg + 1'b1) : (pos_reg - 1'b1);
                            end
                            step_next = 1'b1;
                        end
                    end
                end
            end
            MODE_MOVE:
            begin
                run_next  = 1'b0;
                rate_next = '0;
                if (move_blocked)
                begin
                    status_next  = STATUS_ABORTED;
                    trigger_next = TRIG_CANNOT_MOVE;
                end
                else
                begin
                    status_next    = STATUS_EXECUTING;
                    trigger_next   = TRIG_NONE;
                    target_next    = move_target;
                    force_lim_next = move_force;
                    inc_en_next    = 1'b1;
                    inc_up_next    = move_fwd;
                    dir_fwd_next   = move_fwd;
                    rate_next      = req_rate;
                    run_next       = 1'b1;
                end
            end
            MODE_ROTATE:
            begin
                if (status_reg != STATUS_EXECUTING)
                begin
                    force_lim_next = max_force_reg;
                    target_next    = pos_reg + POSITION_BITS'(ROTATE_SPAN);
                    inc_en_next    = 1'b0;
                    inc_up_next    = 1'b0;
                    status_next    = STATUS_EXECUTING;
                    trigger_next   = TRIG_NONE;
                    dir_fwd_next   = item.rotate_forward;
                    rate_next      = req_rate;
                    run_next       = 1'b1;
                end
            end
            MODE_STOP:
            begin
                run_next     = 1'b0;
                rate_next    = '0;
                status_next  = STATUS_ABORTED;
                trigger_next = TRIG_EXT_STOP;
            end
            MODE_ZERO:
            begin
                pos_next = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        result.status      = status_next;
        result.trigger     = trigger_next;
        result.position    = 32'(pos_next);
        result.step_level  = step_next;
        result.dir_forward = dir_fwd_next;
        result.power_on    = run_next;
        result.step_rate   = rate_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_rate_reg  <= MIN_RATE_RESET;
            max_rate_reg  <= MAX_RATE_RESET;
            max_force_reg <= MAX_FORCE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MIN_RATE:  min_rate_reg  <= cfg_wdata[11:0];
                CFG_MAX_RATE:  max_rate_reg  <= cfg_wdata[11:0];
                CFG_MAX_FORCE: max_force_reg <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg    <= STATUS_NONE;
            trigger_reg   <= TRIG_NONE;
            pos_reg       <= '0;
            target_reg    <= '0;
            force_lim_reg <= '0;
            inc_en_reg    <= 1'b0;
            inc_up_reg    <= 1'b0;
            dir_fwd_reg   <= 1'b0;
            step_reg      <= 1'b0;
            run_reg       <= 1'b0;
            rate_reg      <= '0;
        end
        else if (fire)
        begin
            status_reg    <= status_next;
            trigger_reg   <= trigger_next;
            pos_reg       <= pos_next;
            target_reg    <= target_next;
            force_lim_reg <= force_lim_next;
            inc_en_reg    <= inc_en_next;
            inc_up_reg    <= inc_up_next;
            dir_fwd_reg   <= dir_fwd_next;
            step_reg      <= step_next;
            run_reg       <= run_next;
            rate_reg      <= rate_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/smc_out_stage.sv @@
// Result register holding one result until the downstream side takes it.
`default_nettype none

module smc_out_stage (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             load,
    input  wire smc_pkg::result_t result,
    input  wire logic             out_stall,
    output logic                  out_valid,
    output logic                  ready,
    output smc_pkg::result_t      out_result
);
    import smc_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign ready      = !valid_reg || !out_stall;
    assign valid_next = load || (valid_reg && out_stall);
    assign out_valid  = valid_reg;
    assign out_result = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

endmodule

`default_nettype wire

@@ rtl/stepper_move_controller_core.sv @@
// Top level of the step/direction stepper move controller.
//
//  Channel  Handshake             Payload
//  in       in_valid / in_stall   mode, relative, target_offset, rate_request,
//                                 force_limit, rotate_forward, limit_forward,
//                                 limit_back, force_sample
//  out      out_valid / out_stall status, trigger, position, step_level,
//                                 dir_forward, power_on, step_rate
//  cfg      cfg_we                cfg_index, cfg_wdata
//
//  One item a cycle while the result side is not stalled.
//  Input register, then the state update into the result register in one pass.
//  Reset clears all control state and loads the rate and force defaults.
//  A stalled result holds the executor; one more item waits in the input register.
`default_nettype none

module stepper_move_controller_core #(
    parameter int POSITION_BITS = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [2:0]         mode,
    input  wire logic               relative,
    input  wire logic signed [31:0] target_offset,
    input  wire logic [15:0]        rate_request,
    input  wire logic signed [15:0] force_limit,
    input  wire logic               rotate_forward,
    input  wire logic               limit_forward,
    input  wire logic               limit_back,
    input  wire logic signed [15:0] force_sample,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [1:0]              status,
    output logic [2:0]              trigger,
    output logic signed [31:0]      position,
    output logic                    step_level,
    output logic                    dir_forward,
    output logic                    power_on,
    output logic [11:0]             step_rate,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [15:0]        cfg_wdata
);
    import smc_pkg::*;

    item_t   in_item;
    item_t   item;
    logic    item_valid;
    logic    ready;
    logic    fire;
    result_t result;
    result_t out_result;

    always_comb
    begin
        in_item.mode           = mode;
        in_item.relative       = relative;
        in_item.target_offset  = target_offset;
        in_item.rate_request   = rate_request;
        in_item.force_limit    = force_limit;
        in_item.rotate_forward = rotate_forward;
        in_item.limit_forward  = limit_forward;
        in_item.limit_back     = limit_back;
        in_item.force_sample   = force_sample;
    end

    assign fire = item_valid && ready;

    smc_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .take       (ready),
        .item_valid (item_valid),
        .item       (item)
    );

    smc_exec #(
        .POSITION_BITS (POSITION_BITS)
    ) u_exec (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .result    (result)
    );

    smc_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (fire),
        .result     (result),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .ready      (ready),
        .out_result (out_result)
    );

    assign status      = out_result.status;
    assign trigger     = out_result.trigger;
    assign position    = out_result.position;
    assign step_level  = out_result.step_level;
    assign dir_forward = out_result.dir_forward;
    assign power_on    = out_result.power_on;
    assign step_rate   = out_result.step_rate;

endmodule

`default_nettype wire

@@ verif/stepper_move_controller_core_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the stepper move controller core, random and directed commands.
module stepper_move_controller_core_tb;
    import smc_pkg::*;

    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_PERIOD = 400;
    localparam int HOLD_SPAN   = 150;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    item_t       shown = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = CFG_MIN_RATE;
    logic [15:0] cfg_wdata = '0;

    wire [2:0]         mode           = shown.mode;
    wire               relative       = shown.relative;
    wire signed [31:0] target_offset  = shown.target_offset;
    wire [15:0]        rate_request   = shown.rate_request;
    wire signed [15:0] force_limit    = shown.force_limit;
    wire               rotate_forward = shown.rotate_forward;
    wire               limit_forward  = shown.limit_forward;
    wire               limit_back     = shown.limit_back;
    wire signed [15:0] force_sample   = shown.force_sample;

    logic [1:0]         status;
    logic [2:0]         trigger;
    logic signed [31:0] position;
    logic               step_level;
    logic               dir_forward;
    logic               power_on;
    logic [11:0]        step_rate;

    item_t   pending_items[$];
    result_t expected_results[$];
    int      mismatch_count = 0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;
    logic    pressure_on = 1'b0;
    int      hold_tick = 0;
    int      quiet_cycles = 0;

    logic [11:0]        reg_min_rate = MIN_RATE_RESET;
    logic [11:0]        reg_max_rate = MAX_RATE_RESET;
    logic signed [15:0] reg_max_force = MAX_FORCE_RESET;

    logic [1:0]         ctl_status = STATUS_NONE;
    logic [2:0]         ctl_cause = TRIG_NONE;
    logic signed [31:0] ctl_pos = '0;
    logic signed [31:0] ctl_target = '0;
    logic signed [15:0] ctl_force_lim = '0;
    int                 ctl_inc = 0;
    logic               ctl_dir = 1'b0;
    logic               ctl_line = 1'b0;
    logic               ctl_run = 1'b0;
    logic [11:0]        ctl_rate = '0;

    stepper_move_controller_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .mode           (mode),
        .relative       (relative),
        .target_offset  (target_offset),
        .rate_request   (rate_request),
        .force_limit    (force_limit),
        .rotate_forward (rotate_forward),
        .limit_forward  (limit_forward),
        .limit_back     (limit_back),
        .force_sample   (force_sample),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .trigger        (trigger),
        .position       (position),
        .step_level     (step_level),
        .dir_forward    (dir_forward),
        .power_on       (power_on),
        .step_rate      (step_rate),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata)
    );

    always #10 clk = ~clk;

    task automatic halt_with(input logic [1:0] st, input logic [2:0] tr);
        ctl_run = 1'b0;
        ctl_rate = '0;
        ctl_status = st;
        ctl_cause = tr;
    endtask

    task automatic drive_at(input logic [15:0] req);
        int r;
        r = req;
        if (r < reg_min_rate)
        begin
            r = reg_min_rate;
        end
        if (r > reg_max_rate)
        begin
            r = reg_max_rate;
        end
        ctl_rate = r[11:0];
        ctl_run = 1'b1;
    endtask

    task automatic advance_controller(input item_t it);
        logic signed [31:0] goal;
        logic               fwd;
        result_t            res;
        case (it.mode)
            MODE_TICK:
            begin
                if (ctl_run)
                begin
                    if (ctl_line)
                    begin
                        ctl_line = 1'b0;
                    end
                    else if (ctl_dir && it.limit_forward)
                    begin
                        halt_with(STATUS_ABORTED, TRIG_FWD_SWITCH);
                    end
                    else if (!ctl_dir && it.limit_back)
                    begin
                        ctl_pos = '0;
                        halt_with(STATUS_ABORTED, TRIG_BACK_SWITCH);
                    end
                    else if (ctl_dir && $signed(it.force_sample) >= ctl_force_lim)
                    begin
                        halt_with(STATUS_ABORTED, TRIG_FORCE);
                    end
                    else if (ctl_pos == ctl_target)
                    begin
                        halt_with(STATUS_FINISHED, TRIG_NONE);
                    end
                    else
                    begin
                        if (ctl_inc > 0)
                        begin
                            ctl_pos = ctl_pos + 32'sd1;
                        end
                        else if (ctl_inc < 0)
                        begin
                            ctl_pos = ctl_pos - 32'sd1;
                        end
                        ctl_line = 1'b1;
                    end
                end
            end
            MODE_MOVE:
            begin
                goal = $signed(it.target_offset);
                if (it.relative)
                begin
                    goal = goal + ctl_pos;
                end
                fwd = (goal >= ctl_pos);
                if ((fwd && it.limit_forward) || (!fwd && it.limit_back))
                begin
                    halt_with(STATUS_ABORTED, TRIG_CANNOT_MOVE);
                end
                else
                begin
                    ctl_status = STATUS_EXECUTING;
                    ctl_cause = TRIG_NONE;
                    ctl_target = goal;
                    ctl_force_lim = ($signed(it.force_limit) < reg_max_force) ?
                                    $signed(it.force_limit) : reg_max_force;
                    ctl_inc = fwd ? 1 : -1;
                    ctl_dir = fwd;
                    drive_at(it.rate_request);
                end
            end
            MODE_ROTATE:
            begin
                if (ctl_status != STATUS_EXECUTING)
                begin
                    ctl_force_lim = reg_max_force;
                    ctl_target = ctl_pos + ROTATE_SPAN;
                    ctl_inc = 0;
                    ctl_status = STATUS_EXECUTING;
                    ctl_cause = TRIG_NONE;
                    ctl_dir = it.rotate_forward;
                    drive_at(it.rate_request);
                end
            end
            MODE_STOP:
            begin
                halt_with(STATUS_ABORTED, TRIG_EXT_STOP);
            end
            MODE_ZERO:
            begin
                ctl_pos = '0;
            end
            default:
            begin
            end
        endcase
        res.status = ctl_status;
        res.trigger = ctl_cause;
        res.position = ctl_pos;
        res.step_level = ctl_line;
        res.dir_forward = ctl_dir;
        res.power_on = ctl_run;
        res.step_rate = ctl_rate;
        expected_results.push_back(res);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                advance_controller(shown);
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    shown <= pending_items.pop_front();
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result transfer with nothing outstanding");
                    mismatch_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("status", want.status, status);
                    check_field("trigger", want.trigger, trigger);
                    check_field("position", want.position, position);
                    check_field("step_level", want.step_level, step_level);
                    check_field("dir_forward", want.dir_forward, dir_forward);
                    check_field("power_on", want.power_on, power_on);
                    check_field("step_rate", want.step_rate, step_rate);
                end
            end
            if (pressure_on)
            begin
                hold_tick <= hold_tick + 1;
                out_stall <= (hold_tick % HOLD_PERIOD) < HOLD_SPAN;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("[stepper_move_controller_core] ERROR");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_MIN_RATE: reg_min_rate = val[11:0];
            CFG_MAX_RATE: reg_max_rate = val[11:0];
            CFG_MAX_FORCE: reg_max_force = val;
            default:
            begin
            end
        endcase
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_items.size() != 0 || in_valid || expected_results.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    function automatic item_t random_item();
        item_t it;
        it.mode = $urandom_range(7);
        it.relative = $urandom_range(1);
        it.target_offset = $urandom;
        it.rate_request = $urandom;
        it.force_limit = $urandom;
        it.rotate_forward = $urandom_range(1);
        it.limit_forward = $urandom_range(1);
        it.limit_back = $urandom_range(1);
        it.force_sample = $urandom;
        return it;
    endfunction

    task automatic push_tick(input logic lf, input logic lb, input logic [15:0] fs);
        item_t it;
        it = random_item();
        it.mode = MODE_TICK;
        it.limit_forward = lf;
        it.limit_back = lb;
        it.force_sample = fs;
        pending_items.push_back(it);
    endtask

    task automatic push_ticks(input int n);
        logic [15:0] fs;
        repeat (n)
        begin
            if ($urandom_range(39) == 0)
            begin
                fs = $urandom;
            end
            else
            begin
                fs = $urandom_range(0, 300) - 150;
            end
            push_tick($urandom_range(39) == 0, $urandom_range(39) == 0, fs);
        end
    endtask

    task automatic queue_traffic(input int n);
        item_t it;
        int    made;
        int    pick;
        made = 0;
        while (made < n)
        begin
            pick = $urandom_range(99);
            it = random_item();
            if (pick < 55)
            begin
                it.mode = MODE_MOVE;
                if ($urandom_range(9) != 0)
                begin
                    it.relative = 1'b1;
                    it.target_offset = $urandom_range(0, 40) - 20;
                end
                if ($urandom_range(3) == 0)
                begin
                    it.rate_request = $urandom_range(0, 300);
                end
                if ($urandom_range(3) != 0)
                begin
                    it.force_limit = $urandom_range(200, 32767);
                end
                it.limit_forward = ($urandom_range(9) == 0);
                it.limit_back = ($urandom_range(9) == 0);
                pending_items.push_back(it);
                push_ticks($urandom_range(4, 50));
                made += 1;
            end
            else if (pick < 70)
            begin
                it.mode = MODE_ROTATE;
                pending_items.push_back(it);
                push_ticks($urandom_range(5, 30));
                made += 1;
            end
            else if (pick < 80)
            begin
                it.mode = MODE_STOP;
                pending_items.push_back(it);
                made += 1;
            end
            else if (pick < 86)
            begin
                it.mode = MODE_ZERO;
                pending_items.push_back(it);
                made += 1;
            end
            else
            begin
                pending_items.push_back(it);
                if (it.mode <= MODE_ZERO)
                begin
                    made += 1;
                end
            end
            made += (pick < 70) ? 20 : 0;
        end
    endtask

    task automatic run_phase(input int send_pct, input int recv_pct, input logic squeeze,
                             input int n);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        pressure_on = squeeze;
        queue_traffic(n);
        wait_drained();
        pressure_on = 1'b0;
    endtask

    initial
    begin
        item_t it;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        push_tick(1'b0, 1'b0, 16'h0000);
        it = '0;
        it.mode = MODE_MOVE;
        it.target_offset = 32'd3;
        it.rate_request = 16'd0;
        it.force_limit = 16'h7FFF;
        pending_items.push_back(it);
        repeat (8) push_tick(1'b0, 1'b0, 16'h8000);
        it = '0;
        it.mode = MODE_MOVE;
        it.relative = 1'b1;
        it.target_offset = 32'hFFFF_FFFE;
        it.rate_request = 16'hFFFF;
        it.force_limit = 16'h8000;
        pending_items.push_back(it);
        push_tick(1'b0, 1'b0, 16'h0000);
        push_tick(1'b0, 1'b0, 16'h0000);
        push_tick(1'b0, 1'b1, 16'h0000);
        it = '0;
        it.mode = MODE_MOVE;
        it.target_offset = 32'd5;
        it.limit_forward = 1'b1;
        pending_items.push_back(it);
        it = '0;
        it.mode = MODE_MOVE;
        it.relative = 1'b1;
        it.target_offset = 32'h8000_0000;
        it.limit_back = 1'b1;
        pending_items.push_back(it);
        it = '0;
        it.mode = MODE_ROTATE;
        it.rotate_forward = 1'b1;
        it.rate_request = 16'd50;
        pending_items.push_back(it);
        it.rotate_forward = 1'b0;
        pending_items.push_back(it);
        push_tick(1'b0, 1'b0, 16'h7FFF);
        it = '0;
        it.mode = MODE_MOVE;
        it.target_offset = 32'h7FFF_FFFF;
        it.force_limit = 16'h7FFF;
        it.rate_request = 16'd700;
        pending_items.push_back(it);
        push_tick(1'b0, 1'b0, 16'h0000);
        it = '0;
        it.mode = MODE_STOP;
        pending_items.push_back(it);
        it = '0;
        it.mode = MODE_MOVE;
        it.relative = 1'b1;
        it.target_offset = 32'h7FFF_FFFF;
        pending_items.push_back(it);
        push_tick(1'b0, 1'b1, 16'h0000);
        push_tick(1'b0, 1'b1, 16'h0000);
        it = '0;
        it.mode = MODE_ZERO;
        pending_items.push_back(it);
        for (int m = 5; m < 8; m++)
        begin
            it = random_item();
            it.mode = m;
            pending_items.push_back(it);
        end
        wait_drained();

        run_phase(0, 0, 1'b0, 250);
        write_reg(CFG_MIN_RATE, 16'd1);
        write_reg(CFG_MAX_RATE, 16'd4095);
        write_reg(CFG_MAX_FORCE, 16'h7FFF);
        run_phase(87, 0, 1'b0, 250);
        write_reg(CFG_MIN_RATE, 16'd4095);
        write_reg(CFG_MAX_RATE, 16'd1);
        write_reg(CFG_MAX_FORCE, 16'h8000);
        run_phase(0, 87, 1'b0, 250);
        write_reg(CFG_MIN_RATE, $urandom_range(1, 4095));
        write_reg(CFG_MAX_RATE, $urandom_range(1, 4095));
        write_reg(CFG_MAX_FORCE, $urandom_range(0, 65535));
        run_phase(16, 16, 1'b0, 250);
        write_reg(CFG_MIN_RATE, 16'd200);
        write_reg(CFG_MAX_RATE, 16'd800);
        write_reg(CFG_MAX_FORCE, 16'd0);
        run_phase(0, 0, 1'b1, 250);

        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("[stepper_move_controller_core] OK");
        end
        else
        begin
            $display("[stepper_move_controller_core] ERROR");
        end
        $finish;
    end

endmodule

@@ stepper_move_controller_core.f @@
rtl/smc_pkg.sv
rtl/smc_in_stage.sv
rtl/smc_exec.sv
rtl/smc_out_stage.sv
rtl/stepper_move_controller_core.sv
verif/stepper_move_controller_core_tb.sv
